// ----- sv/tsf_pkg.sv -----
// Package for the triangle scanline fill block: canvas defaults, widths and
// shared control structs. No dependencies.
package tsf_pkg;
	localparam int CANVAS_WIDTH_DEF  = 256;
	localparam int CANVAS_HEIGHT_DEF = 256;
	localparam int CW = 8;
	localparam int PIXW = 24;

	typedef struct packed {
		logic          mode;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] bx;
		logic [CW-1:0] by_coord;
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [PIXW-1:0] fill_color;
		logic [CW-1:0] read_x;
		logic [CW-1:0] read_y;
	} in_item_t;

	typedef struct packed {
		logic            was_read;
		logic [PIXW-1:0] pixel_color;
	} out_item_t;

	// one frame-buffer access request from the sequencer
	typedef struct packed {
		logic            wr;
		logic            rd;
		logic [CW-1:0]   x;
		logic [CW-1:0]   y;
		logic [PIXW-1:0] data;
	} fb_req_t;

	// divider start request: numerator and divisor
	typedef struct packed {
		logic                start;
		logic [2*CW-1:0]     num;
		logic [CW-1:0]       den;
	} div_req_t;
endpackage

// ----- sv/tsf_if.sv -----
// Valid/ready stream interfaces for the triangle scanline fill block.
// Depends on tsf_pkg.
interface tsf_in_if;
	logic              valid;
	logic              ready;
	tsf_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tsf_out_if;
	logic               valid;
	logic               ready;
	tsf_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/tsf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle: 16-bit numerator by
// 8-bit divisor. Depends on tsf_pkg.
module tsf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsf_pkg::div_req_t            req,
	output logic                         busy,
	output logic [2*tsf_pkg::CW-1:0]     quo
);
	localparam int NW = 2 * tsf_pkg::CW;
	logic [NW-1:0]         q_q;
	logic [tsf_pkg::CW:0]  rem_q;
	logic [tsf_pkg::CW-1:0] den_q;
	logic [$clog2(NW+1)-1:0] cnt_q;
	logic [tsf_pkg::CW+1:0] trial;
	logic [tsf_pkg::CW:0]  sh;

	assign sh    = {rem_q[tsf_pkg::CW-1:0], q_q[NW-1]};
	assign trial = {1'b0, sh} - {2'b00, den_q};
	assign busy  = (cnt_q != '0);
	assign quo   = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ($clog2(NW+1))'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy) begin
			if (!trial[tsf_pkg::CW+1]) begin
				rem_q <= trial[tsf_pkg::CW:0];
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- sv/tsf_fb.sv -----
// Frame buffer: one synchronous RAM with registered read, plus a clearing
// sweep after reset. Depends on tsf_pkg.
module tsf_fb #(
	parameter int CANVAS_WIDTH  = tsf_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = tsf_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tsf_pkg::fb_req_t          req,
	output logic                      clearing,
	output logic [tsf_pkg::PIXW-1:0]  rdata
);
	localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	logic [tsf_pkg::PIXW-1:0] mem [DEPTH];
	logic [AW:0]  clr_q;
	logic [AW-1:0] addr;

	assign clearing = (clr_q != (AW+1)'(DEPTH));
	assign addr = AW'(32'(req.y) * 32'(CANVAS_WIDTH) + 32'(req.x));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (req.wr) begin
			mem[addr] <= req.data;
		end
		if (req.rd) begin
			rdata <= mem[addr];
		end
	end

`ifndef SYNTHESIS
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.wr && !req.rd)
		else $error("frame buffer access during clear");
	a_clear_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |=> !clearing)
		else $error("clear restarted");
	a_wr_on_canvas: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr |-> (32'(req.x) < CANVAS_WIDTH) && (32'(req.y) < CANVAS_HEIGHT))
		else $error("write off canvas");
`endif
endmodule

// ----- sv/tsf_seq.sv -----
// Draw/read sequencer: vertex sort, row and span stepping, edge divisions
// through tsf_div. Depends on tsf_pkg and tsf_if.
module tsf_seq #(
	parameter int CANVAS_WIDTH  = tsf_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = tsf_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	tsf_in_if.sink                   in_ch,
	tsf_out_if.source                out_ch,
	input  logic                     clearing,
	input  logic [tsf_pkg::PIXW-1:0] rdata,
	output tsf_pkg::fb_req_t         fb,
	output tsf_pkg::div_req_t        dreq,
	input  logic                     dbusy,
	input  logic [2*tsf_pkg::CW-1:0] dquo
);
	localparam int W = tsf_pkg::CW;
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_ROW = 4'd3,
		S_DL = 4'd4, S_DLW = 4'd5, S_DR = 4'd6, S_DRW = 4'd7, S_SPAN = 4'd8,
		S_DONE = 4'd9;

	logic [3:0] st_q;
	logic [W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, y_q, xl_q, xc_q, xe_q;
	logic [tsf_pkg::PIXW-1:0] col_q;
	logic ov_q;
	tsf_pkg::out_item_t ob_q;

	// sort network on the incoming vertices
	logic [W-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
	always_comb begin
		tx = '0; ty = '0;
		sx0 = in_ch.payload.ax; sy0 = in_ch.payload.ay;
		sx1 = in_ch.payload.bx; sy1 = in_ch.payload.by_coord;
		sx2 = in_ch.payload.cx; sy2 = in_ch.payload.cy;
		if (sy0 > sy1) begin
			tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
		end
		if (sy0 > sy2) begin
			tx = sx0; ty = sy0; sx0 = sx2; sy0 = sy2; sx2 = tx; sy2 = ty;
		end
		if (sy1 > sy2) begin
			tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
		end
	end

	// edge operands: start, end, for left or right edge
	logic lsel;
	logic [W-1:0] esx, esy, eex, eey, ady, adx;
	logic eneg, ezero;
	logic [2*W-1:0] eprod;
	logic [W-1:0] eres;
	logic [2*W-1:0] qadj;
	always_comb begin
		lsel = (st_q == S_DL) || (st_q == S_DLW);
		if (lsel) begin
			esx = x0_q; esy = y0_q; eex = x2_q; eey = y2_q;
		end else if (y_q >= y1_q) begin
			esx = x1_q; esy = y1_q; eex = x2_q; eey = y2_q;
		end else begin
			esx = x0_q; esy = y0_q; eex = x1_q; eey = y1_q;
		end
		ady   = eey - esy;
		ezero = (ady == '0);
		eneg  = eex < esx;
		adx   = eneg ? esx - eex : eex - esx;
		eprod = (2*W)'(y_q - esy) * (2*W)'(adx);
		// floor for negative slope: -ceil(p/d)
		qadj  = dquo;
		eres  = eneg ? esx - W'(qadj) : esx + W'(qadj);
	end
	logic [2*W-1:0] ceil_num;
	assign ceil_num = eneg ? eprod + (2*W)'(ady) - 1'b1 : eprod;

	assign dreq.start = ((st_q == S_DL) || (st_q == S_DR)) && !ezero;
	assign dreq.num   = ceil_num;
	assign dreq.den   = ady;

	// post a finished result once the result register is free or drains this cycle
	logic post;
	assign post = ((st_q == S_RDW) || (st_q == S_DONE)) && (!ov_q || out_ch.ready);

	assign in_ch.ready  = (st_q == S_IDLE) && !clearing;
	assign out_ch.valid = ov_q;
	assign out_ch.payload = ob_q;

	logic onc;
	assign onc = (32'(xc_q) < CANVAS_WIDTH) && (32'(y_q) < CANVAS_HEIGHT);
	always_comb begin
		fb = '0;
		fb.x = xc_q; fb.y = y_q; fb.data = col_q;
		fb.wr = (st_q == S_SPAN) && onc;
		fb.rd = (st_q == S_RD) && onc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (post) ov_q <= 1'b1;
			else if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					st_q <= in_ch.payload.mode ? S_RD : S_ROW;
				end
				S_RD:   st_q <= S_RDW;
				S_RDW:  if (post) st_q <= S_IDLE;
				S_ROW:  st_q <= S_DL;
				S_DL:   st_q <= ezero ? S_DR : S_DLW;
				S_DLW:  if (!dbusy) st_q <= S_DR;
				S_DR:   st_q <= ezero ? S_SPAN : S_DRW;
				S_DRW:  if (!dbusy) st_q <= S_SPAN;
				S_SPAN: if (xc_q == xe_q) st_q <= (y_q == y2_q) ? S_DONE : S_ROW;
				S_DONE: if (post) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic [W-1:0] xr_n;
	always_comb begin
		xr_n = ezero ? esx : eres;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (in_ch.valid && in_ch.ready) begin
				x0_q <= sx0; y0_q <= sy0; x1_q <= sx1; y1_q <= sy1;
				x2_q <= sx2; y2_q <= sy2;
				y_q <= in_ch.payload.mode ? in_ch.payload.read_y : sy0;
				col_q <= in_ch.payload.fill_color;
				xc_q <= in_ch.payload.read_x;
			end
			S_RDW: if (post) begin
				ob_q.was_read <= 1'b1;
				ob_q.pixel_color <= onc ? rdata : '0;
			end
			S_DL:  if (ezero) xl_q <= esx;
			S_DLW: if (!dbusy) xl_q <= eres;
			S_DR:  if (ezero) begin
				xc_q <= (xl_q < esx) ? xl_q : esx;
				xe_q <= (xl_q < esx) ? esx : xl_q;
			end
			S_DRW: if (!dbusy) begin
				xc_q <= (xl_q < xr_n) ? xl_q : xr_n;
				xe_q <= (xl_q < xr_n) ? xr_n : xl_q;
			end
			S_SPAN: begin
				xc_q <= xc_q + 1'b1;
				if (xc_q == xe_q) y_q <= y_q + 1'b1;
			end
			S_DONE: if (post) begin
				ob_q.was_read <= 1'b0;
				ob_q.pixel_color <= '0;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> (st_q == S_IDLE) && !clearing)
		else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> ov_q && $stable(ob_q))
		else $error("result lost under stall");
	a_span_ord: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SPAN) |-> xc_q <= xe_q)
		else $error("span overrun");
`endif
endmodule

// ----- sv/triangle_scanline_fill.sv -----
// Triangle scanline fill, top level: sequencer, edge divider, frame buffer.
// Depends on tsf_pkg, tsf_if, tsf_seq, tsf_div, tsf_fb.
//
// Usage: items arrive on in_ch (valid/ready). mode 0 draws a filled triangle
// with fill_color; mode 1 reads the pixel at read_x, read_y. Each item gives
// one result on out_ch: was_read and pixel_color (zero after a draw).
// A read steps through RD and RDW, which posts the registered pixel. A draw
// steps each row through ROW, the left and right edges (serial divider, 16
// quotient bits, one a cycle; no division for a zero-height edge) and SPAN,
// one write per pixel (single frame-buffer write port), then posts from DONE.
// One item is worked at a time; the next is taken while the result register
// still holds the previous result. A stalled receiver holds the result; the
// following item then waits at its end and blocks new input.
// After reset the frame buffer is cleared one pixel a cycle, all
// CANVAS_WIDTH*CANVAS_HEIGHT pixels (65536 by default), with in_ch not ready.
module triangle_scanline_fill #(
	parameter int CANVAS_WIDTH  = tsf_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = tsf_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tsf_in_if.sink     in_ch,
	tsf_out_if.source  out_ch
);
	tsf_pkg::fb_req_t  fb;
	tsf_pkg::div_req_t dreq;
	logic clearing, dbusy;
	logic [tsf_pkg::PIXW-1:0] rdata;
	logic [2*tsf_pkg::CW-1:0] dquo;

	tsf_seq #(.CANVAS_WIDTH(CANVAS_WIDTH), .CANVAS_HEIGHT(CANVAS_HEIGHT)) u_seq (
		.clk, .arst_n, .in_ch, .out_ch, .clearing, .rdata, .fb, .dreq, .dbusy, .dquo);
	tsf_div u_div (.clk, .arst_n, .req(dreq), .busy(dbusy), .quo(dquo));
	tsf_fb #(.CANVAS_WIDTH(CANVAS_WIDTH), .CANVAS_HEIGHT(CANVAS_HEIGHT)) u_fb (
		.clk, .arst_n, .req(fb), .clearing, .rdata);
endmodule
